@@ rtl/core/adtsfsl_pkg.sv @@
// shared types, constants and tables for the adts frame sync and lock block
`timescale 1ns / 1ps
`default_nettype none
package adtsfsl_pkg;

    // search phases, one-hot
    typedef enum logic [2:0] {
        PH_HUNT   = 3'b001,
        PH_SKIP   = 3'b010,
        PH_VERIFY = 3'b100
    } t_phase;

    // result status codes
    typedef enum logic [1:0] {
        ST_LOCKED = 2'd0,
        ST_LIMIT  = 2'd1,
        ST_EOS    = 2'd2
    } t_status;

    // configuration register indexes
    localparam logic CFG_SEARCH_LIMIT     = 1'b0;
    localparam logic CFG_REQUIRED_MATCHES = 1'b1;

    localparam logic [15:0] SEARCH_LIMIT_RST     = 16'd16384;
    localparam logic [2:0]  REQUIRED_MATCHES_RST = 3'd4;

    // decoded fields of one header candidate
    typedef struct packed {
        logic        ok;
        logic [3:0]  sri;
        logic [2:0]  ch;
        logic [12:0] len;
    } t_hdr;

    function automatic logic [16:0] rate_hz(input logic [3:0] sri);
        logic [16:0] r;
        case (sri)
            4'd0:    r = 17'd96000;
            4'd1:    r = 17'd88200;
            4'd2:    r = 17'd64000;
            4'd3:    r = 17'd48000;
            4'd4:    r = 17'd44100;
            4'd5:    r = 17'd32000;
            4'd6:    r = 17'd24000;
            4'd7:    r = 17'd22050;
            4'd8:    r = 17'd16000;
            4'd9:    r = 17'd12000;
            4'd10:   r = 17'd11025;
            4'd11:   r = 17'd8000;
            4'd12:   r = 17'd7350;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] chan_count(input logic [2:0] ch);
        logic [3:0] c;
        case (ch)
            3'd7:    c = 4'd8;
            default: c = {1'b0, ch};
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/adtsfsl_hdr_parse.sv @@
// decodes an 8-byte window into adts header fields and a validity flag
`timescale 1ns / 1ps
`default_nettype none
module adtsfsl_hdr_parse (
    input  wire logic [63:0]       i_window,
    output adtsfsl_pkg::t_hdr      o_hdr
);
    import adtsfsl_pkg::*;

    logic [7:0] b0, b1, b2, b3, b4, b5;
    logic       sync;

    assign b0 = i_window[7:0];
    assign b1 = i_window[15:8];
    assign b2 = i_window[23:16];
    assign b3 = i_window[31:24];
    assign b4 = i_window[39:32];
    assign b5 = i_window[47:40];

    // 12-bit sync word, ignoring id/layer/protection bits
    assign sync = (b0 == 8'hFF) && (b1[7:4] == 4'hF);

    always_comb begin
        o_hdr.sri = b2[5:2];
        o_hdr.ch  = {b2[0], b3[7:6]};
        o_hdr.len = {b3[1:0], b4, b5[7:5]};
        o_hdr.ok  = sync && (o_hdr.sri < 4'd13) && (o_hdr.ch != 3'd0)
                    && (o_hdr.len > 13'd7);
    end

endmodule
`default_nettype wire

@@ rtl/core/adts_frame_sync_lock.sv @@
// top level: adts header search, frame skipping and lock detection
// an accepted item passes from the input register into the result register
// throughput: one byte per cycle while no result waits to be taken; the window shift and counter update fit one stage
// any item stalls while an earlier result is not yet taken
// reset (synchronous, active low) clears the search state and loads
// search_limit 16384 and required_matches 4
`timescale 1ns / 1ps
`default_nettype none
module adts_frame_sync_lock (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_stream,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [16:0]      o_sample_rate_hz,
    output logic [3:0]       o_channel_count,
    output logic [63:0]      o_header_word
);
    import adtsfsl_pkg::*;

    // configuration
    logic [15:0] r_search_limit;
    logic [2:0]  r_req;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eos;

    // search state
    logic [63:0] r_window, n_window;
    logic [3:0]  r_fill, n_fill;
    t_phase      r_phase, n_phase;
    logic [12:0] r_skip, n_skip;
    logic [2:0]  r_match, n_match;
    logic [3:0]  r_sri, n_sri;
    logic [2:0]  r_ch, n_ch;
    logic [15:0] r_bytes, n_bytes;

    logic        emit, emit_locked;
    t_status     emit_status;
    logic        go;
    t_hdr        hdr;

    adtsfsl_hdr_parse u_parse (
        .i_window (n_window),
        .o_hdr    (hdr)
    );

    assign go         = r_in_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || go;

    always_comb begin
        n_window    = {r_in_byte, r_window[63:8]};
        n_fill      = r_fill[3] ? r_fill : r_fill + 4'd1;
        n_bytes     = (r_bytes == 16'hFFFF) ? r_bytes : r_bytes + 16'd1;
        n_phase     = r_phase;
        n_skip      = r_skip;
        n_match     = r_match;
        n_sri       = r_sri;
        n_ch        = r_ch;
        emit        = 1'b0;
        emit_locked = 1'b0;
        emit_status = ST_EOS;

        case (r_phase)
            PH_SKIP: begin
                n_skip = r_skip - 13'd1;
                if (n_skip == 13'd0) begin
                    n_phase = PH_VERIFY;
                    n_fill  = 4'd0;
                end
            end
            PH_VERIFY: begin
                if (n_fill[3]) begin
                    if (hdr.ok && hdr.sri == r_sri && hdr.ch == r_ch) begin
                        n_match = r_match + 3'd1;
                        if (n_match >= r_req) begin
                            emit        = 1'b1;
                            emit_locked = 1'b1;
                            emit_status = ST_LOCKED;
                        end else begin
                            n_skip  = hdr.len - 13'd8;
                            n_phase = (n_skip != 13'd0) ? PH_SKIP : PH_VERIFY;
                            n_fill  = 4'd0;
                        end
                    end else begin
                        // resume byte-wise search from the failed header
                        n_phase = PH_HUNT;
                    end
                end
            end
            default: begin
                if (!r_in_eos && n_fill[3]) begin
                    if (n_bytes >= r_search_limit) begin
                        emit        = 1'b1;
                        emit_status = ST_LIMIT;
                    end else if (hdr.ok) begin
                        n_sri   = hdr.sri;
                        n_ch    = hdr.ch;
                        n_match = 3'd0;
                        if (r_req == 3'd0) begin
                            emit        = 1'b1;
                            emit_locked = 1'b1;
                            emit_status = ST_LOCKED;
                        end else begin
                            n_skip  = hdr.len - 13'd8;
                            n_phase = (n_skip != 13'd0) ? PH_SKIP : PH_VERIFY;
                            n_fill  = 4'd0;
                        end
                    end
                end
            end
        endcase

        // end of stream ends the search unless this byte gave lock
        if (r_in_eos && !emit) begin
            emit        = 1'b1;
            emit_status = ST_EOS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_limit <= SEARCH_LIMIT_RST;
            r_req          <= REQUIRED_MATCHES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEARCH_LIMIT:     r_search_limit <= i_cfg_data;
                CFG_REQUIRED_MATCHES: r_req          <= i_cfg_data[2:0];
                default:              r_req          <= r_req;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eos  <= i_end_of_stream;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (go && emit)) begin
            r_window <= '0;
            r_fill   <= '0;
            r_phase  <= PH_HUNT;
            r_skip   <= '0;
            r_match  <= '0;
            r_sri    <= '0;
            r_ch     <= '0;
            r_bytes  <= '0;
        end else if (go) begin
            r_window <= n_window;
            r_fill   <= n_fill;
            r_phase  <= n_phase;
            r_skip   <= n_skip;
            r_match  <= n_match;
            r_sri    <= n_sri;
            r_ch     <= n_ch;
            r_bytes  <= n_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (go && emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && emit) begin
            o_status         <= emit_status;
            o_sample_rate_hz <= emit_locked ? rate_hz(n_sri) : 17'd0;
            o_channel_count  <= emit_locked ? chan_count(n_ch) : 4'd0;
            o_header_word    <= emit_locked ? n_window : 64'd0;
        end
    end

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_LOCKED || o_status == ST_LIMIT
                         || o_status == ST_EOS))
        else $error("result status out of range");

    a_unlocked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_LOCKED)
            |-> (o_sample_rate_hz == 17'd0 && o_channel_count == 4'd0
                 && o_header_word == 64'd0))
        else $error("unlocked result carries stream info");

    a_locked_info: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_LOCKED)
            |-> (o_sample_rate_hz != 17'd0 && o_channel_count != 4'd0))
        else $error("locked result without rate or channels");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 4'd8)
        else $error("window fill above eight bytes");

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SKIP) |-> (r_skip != 13'd0))
        else $error("skipping with zero bytes left");

endmodule
`default_nettype wire

@@ dv/adts_frame_sync_lock_tb.sv @@
// testbench for adts_frame_sync_lock: random byte streams checked against a local sync search model
`timescale 1ns / 1ps
module adts_frame_sync_lock_tb;
    import adtsfsl_pkg::*;

    localparam int NUM_PHASES       = 5;
    localparam int PHASE_BYTES      = 250;
    localparam int DRAIN_CYCLES     = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TIMEOUT_NS       = 2_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } t_stream_byte;

    typedef struct packed {
        t_status     status;
        logic [16:0] rate_hz;
        logic [3:0]  chans;
        logic [63:0] hdr;
    } t_search_report;

    typedef enum int {
        FLAW_NONE,
        FLAW_SYNC_LOW,
        FLAW_SYNC_HIGH,
        FLAW_RATE,
        FLAW_CHANNELS,
        FLAW_LENGTH,
        FLAW_MISMATCH
    } t_hdr_flaw;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = CFG_SEARCH_LIMIT;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_data_byte = '0;
    logic        i_end_of_stream = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [16:0] o_sample_rate_hz;
    logic [3:0]  o_channel_count;
    logic [63:0] o_header_word;

    adts_frame_sync_lock u_top (
        .i_clk,
        .i_rst_n,
        .i_cfg_we,
        .i_cfg_index,
        .i_cfg_data,
        .i_in_valid,
        .o_in_ready,
        .i_data_byte,
        .i_end_of_stream,
        .o_out_valid,
        .i_out_ready,
        .o_status,
        .o_sample_rate_hz,
        .o_channel_count,
        .o_header_word
    );

    always #2 i_clk = ~i_clk;

    // tracking copy of the search state
    logic [63:0] trk_window;
    logic [3:0]  trk_fill;
    t_phase      trk_phase;
    logic [12:0] trk_skip;
    logic [2:0]  trk_matches;
    logic [3:0]  trk_sri;
    logic [2:0]  trk_ch;
    logic [15:0] trk_count;
    logic [15:0] cfg_limit;
    logic [2:0]  cfg_matches;

    t_search_report search_reports[$];
    t_stream_byte   stream_bytes[$];

    int   mismatch_count = 0;
    int   queued_bytes = 0;
    int   send_gap = 0;
    int   recv_stall = 0;
    logic byte_taken = 1'b0;
    logic idle_on = 1'b1;
    logic long_hold_due = 1'b0;
    logic long_hold_done = 1'b0;
    logic big_frame_due = 1'b0;

    function automatic logic [16:0] sri_to_hz(input logic [3:0] sri);
        logic [16:0] hz;
        case (sri)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            4'd12:   hz = 17'd7350;
            default: hz = 17'd0;
        endcase
        return hz;
    endfunction

    function automatic t_hdr decode_hdr(input logic [63:0] w);
        t_hdr h;
        h.sri = w[21:18];
        h.ch  = {w[16], w[31:30]};
        h.len = {w[25:24], w[39:32], w[47:45]};
        h.ok  = (w[7:0] == 8'hFF) && (w[15:12] == 4'hF) && (h.sri < 4'd13)
                && (h.ch != 3'd0) && (h.len > 13'd7);
        return h;
    endfunction

    task automatic restart_search();
        trk_window  = '0;
        trk_fill    = '0;
        trk_phase   = PH_HUNT;
        trk_skip    = '0;
        trk_matches = '0;
        trk_sri     = '0;
        trk_ch      = '0;
        trk_count   = '0;
    endtask

    task automatic finish_search(input t_status st);
        t_search_report r;
        r.status  = st;
        r.rate_hz = (st == ST_LOCKED) ? sri_to_hz(trk_sri) : 17'd0;
        r.chans   = (st != ST_LOCKED) ? 4'd0 : (trk_ch == 3'd7) ? 4'd8 : {1'b0, trk_ch};
        r.hdr     = (st == ST_LOCKED) ? trk_window : 64'd0;
        search_reports.push_back(r);
        restart_search();
    endtask

    task automatic begin_skip(input logic [12:0] len);
        trk_skip = len - 13'd8;
        if (trk_skip != '0) begin
            trk_phase = PH_SKIP;
        end else begin
            trk_phase = PH_VERIFY;
        end
        trk_fill = '0;
    endtask

    task automatic sync_search_step(input logic [7:0] b, input logic eos);
        t_hdr h;
        logic ended;
        ended = 1'b0;
        trk_window = {b, trk_window[63:8]};
        if (trk_fill < 4'd8) trk_fill = trk_fill + 4'd1;
        if (trk_count != 16'hFFFF) trk_count = trk_count + 16'd1;
        case (trk_phase)
            PH_SKIP: begin
                trk_skip = trk_skip - 13'd1;
                if (trk_skip == '0) begin
                    trk_phase = PH_VERIFY;
                    trk_fill  = '0;
                end
            end
            PH_VERIFY: begin
                if (trk_fill >= 4'd8) begin
                    h = decode_hdr(trk_window);
                    if (h.ok && h.sri == trk_sri && h.ch == trk_ch) begin
                        trk_matches = trk_matches + 3'd1;
                        if (trk_matches >= cfg_matches) begin
                            finish_search(ST_LOCKED);
                            ended = 1'b1;
                        end else begin
                            begin_skip(h.len);
                        end
                    end else begin
                        // resume byte-wise hunting from the failed header
                        trk_phase = PH_HUNT;
                    end
                end
            end
            default: begin
                // a window completed by the last byte is not searched
                if (!eos && trk_fill >= 4'd8) begin
                    h = decode_hdr(trk_window);
                    if (trk_count >= cfg_limit) begin
                        finish_search(ST_LIMIT);
                        ended = 1'b1;
                    end else if (h.ok) begin
                        trk_sri     = h.sri;
                        trk_ch      = h.ch;
                        trk_matches = '0;
                        if (cfg_matches == '0) begin
                            finish_search(ST_LOCKED);
                            ended = 1'b1;
                        end else begin
                            begin_skip(h.len);
                        end
                    end
                end
            end
        endcase
        // lock on the last byte wins over end of stream
        if (eos && !ended) finish_search(ST_EOS);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SEARCH_LIMIT) begin
            cfg_limit = val;
        end else begin
            cfg_matches = val[2:0];
        end
        @(posedge i_clk);
    endtask

    task automatic put_byte(input logic [7:0] b, input logic eos);
        t_stream_byte s;
        s.data = b;
        s.eos  = eos;
        stream_bytes.push_back(s);
        queued_bytes++;
    endtask

    // biased toward sync-like bytes so false starts are common
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom);
        case ($urandom_range(0, 3))
            0:       b = 8'hFF;
            1:       b[7:4] = 4'hF;
            default: ;
        endcase
        return b;
    endfunction

    task automatic put_noise(input int n);
        for (int i = 0; i < n; i++) put_byte(noise_byte(), $urandom_range(0, 19) == 0);
    endtask

    task automatic put_header(input logic [3:0] sri, input logic [2:0] ch,
                              input logic [12:0] len, input t_hdr_flaw flaw,
                              input logic eos_last);
        logic [7:0]  hb [8];
        logic [3:0]  s;
        logic [2:0]  c;
        logic [12:0] n;
        s = sri;
        c = ch;
        n = len;
        case (flaw)
            FLAW_RATE:     s = 4'($urandom_range(13, 15));
            FLAW_CHANNELS: c = 3'd0;
            FLAW_LENGTH:   n = 13'($urandom_range(0, 7));
            FLAW_MISMATCH: begin
                if ($urandom_range(0, 1) == 0) begin
                    s = 4'((sri + $urandom_range(1, 12)) % 13);
                end else begin
                    c = 3'(ch % 7 + 1);
                end
            end
            default: ;
        endcase
        for (int k = 0; k < 8; k++) hb[k] = 8'($urandom);
        hb[0]      = (flaw == FLAW_SYNC_LOW) ? 8'($urandom_range(0, 254)) : 8'hFF;
        hb[1][7:4] = (flaw == FLAW_SYNC_HIGH) ? 4'($urandom_range(0, 14)) : 4'hF;
        hb[2][5:2] = s;
        hb[2][0]   = c[2];
        hb[3][7:6] = c[1:0];
        hb[3][1:0] = n[12:11];
        hb[4]      = n[10:3];
        hb[5][7:5] = n[2:0];
        for (int k = 0; k < 8; k++) put_byte(hb[k], eos_last && k == 7);
    endtask

    function automatic logic [12:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14) return 13'($urandom_range(8, 16));
        if (r < 19) return 13'($urandom_range(17, 64));
        return 13'($urandom_range(65, 300));
    endfunction

    task automatic put_random_stream();
        logic [3:0]  sri;
        logic [2:0]  ch;
        logic [12:0] len;
        t_hdr_flaw   flaw;
        logic        eos_end;
        int          kind;
        kind = $urandom_range(0, 9);
        sri  = 4'($urandom_range(0, 12));
        ch   = 3'($urandom_range(1, 7));
        if (kind < 6) begin
            // a run of consistent frames, now and then with bad headers
            put_noise($urandom_range(0, 5));
            eos_end = ($urandom_range(0, 3) == 0);
            for (int f = 0; f <= cfg_matches; f++) begin
                // the largest length goes on the last header, whose body is not sent
                if (big_frame_due && f == cfg_matches) begin
                    len = 13'h1FFF;
                    big_frame_due = 1'b0;
                end else begin
                    len = pick_len();
                end
                flaw = ($urandom_range(0, 11) == 0) ? t_hdr_flaw'($urandom_range(1, 6))
                                                    : FLAW_NONE;
                put_header(sri, ch, len, flaw, eos_end && f == cfg_matches);
                if (f < cfg_matches) begin
                    for (int k = 8; k < len; k++) begin
                        put_byte(8'($urandom), $urandom_range(0, 299) == 0);
                    end
                end
            end
        end else if (kind < 8) begin
            put_noise($urandom_range(1, 24));
        end else begin
            flaw = t_hdr_flaw'($urandom_range(0, 5));
            put_header(sri, ch, pick_len(), flaw, 1'b0);
            put_noise($urandom_range(0, 12));
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (stream_bytes.size() != 0 || i_in_valid || search_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin : feed_bytes
        t_stream_byte nxt;
        if (i_rst_n && (!i_in_valid || byte_taken)) begin
            if (send_gap != 0) begin
                send_gap--;
                i_in_valid <= 1'b0;
            end else if (stream_bytes.size() != 0) begin
                nxt = stream_bytes.pop_front();
                i_data_byte     <= nxt.data;
                i_end_of_stream <= nxt.eos;
                i_in_valid      <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : take_results
        if (long_hold_due && !long_hold_done) begin
            long_hold_done = 1'b1;
            recv_stall = LONG_HOLD_CYCLES;
        end
        if (recv_stall != 0) begin
            recv_stall--;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            recv_stall = $urandom_range(0, 14);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_search_report want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (search_reports.size() == 0) begin
                    $error("result with none expected: status %0d", o_status);
                    mismatch_count++;
                end else begin
                    want = search_reports.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatch_count++;
                    end
                    if (o_sample_rate_hz !== want.rate_hz) begin
                        $error("sample_rate_hz: expected %0d, got %0d",
                               want.rate_hz, o_sample_rate_hz);
                        mismatch_count++;
                    end
                    if (o_channel_count !== want.chans) begin
                        $error("channel_count: expected %0d, got %0d",
                               want.chans, o_channel_count);
                        mismatch_count++;
                    end
                    if (o_header_word !== want.hdr) begin
                        $error("header_word: expected %h, got %h", want.hdr, o_header_word);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) sync_search_step(i_data_byte, i_end_of_stream);
            byte_taken = i_in_valid && o_in_ready;
        end
    end

    initial begin
        #TIMEOUT_NS;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [15:0] lim;
        logic [2:0]  req;
        restart_search();
        cfg_limit   = SEARCH_LIMIT_RST;
        cfg_matches = REQUIRED_MATCHES_RST;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero further matches: the first valid header locks at once
        write_reg(CFG_REQUIRED_MATCHES, {13'($urandom), 3'd0});
        put_header(4'd0, 3'd1, 13'd8, FLAW_NONE, 1'b0);
        put_header(4'd12, 3'd7, 13'h1FFF, FLAW_NONE, 1'b0);
        put_byte(8'hFF, 1'b1);
        // header completed by the last byte of the stream is not searched
        put_header(4'd3, 3'd2, 13'd100, FLAW_NONE, 1'b1);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0:       begin lim = 16'hFFFF; req = 3'd7; end
                1:       begin lim = 16'd16;   req = 3'd1; end
                2:       begin lim = 16'd5;    req = 3'd2; end
                3:       begin lim = 16'd300;  req = 3'd3; end
                default: begin lim = 16'd16384; req = 3'd4; end
            endcase
            write_reg(CFG_SEARCH_LIMIT, lim);
            write_reg(CFG_REQUIRED_MATCHES, {13'($urandom), req});
            idle_on <= (p != NUM_PHASES - 1);
            // tiny limit gives a result every few bytes, so a long hold backs up the input
            if (p == 2) long_hold_due <= 1'b1;
            big_frame_due = (p == 0);
            queued_bytes = 0;
            while (queued_bytes < PHASE_BYTES) put_random_stream();
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
